FILE: rtl/iirdf1_pkg.sv
// Package for the direct form I IIR filter: sample and coefficient types,
// register indexes, fixed-point constants and the sequencer's microcode ROM.
// No dependencies.
`default_nettype none

package iirdf1_pkg;

  localparam int DEF_ORDER = 3;
  localparam int MAX_ORDER = 3;
  localparam int NUM_REGS  = 7;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 4;
  localparam int FRAC_BITS = 20;
  localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
  localparam int IDX_W     = 3;
  localparam int STEP_W    = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  typedef enum logic [IDX_W-1:0] {
    REG_B_CUR  = 3'd0,
    REG_B_LAG1 = 3'd1,
    REG_B_LAG2 = 3'd2,
    REG_B_LAG3 = 3'd3,
    REG_A_LAG1 = 3'd4,
    REG_A_LAG2 = 3'd5,
    REG_A_LAG3 = 3'd6
  } reg_idx_t;

  localparam coef_t COEF_B_CUR_RST = 24'sd1048576;

  typedef enum logic [1:0] {
    SRC_X_CUR  = 2'd0,
    SRC_X_HIST = 2'd1,
    SRC_Y_HIST = 2'd2
  } src_t;

  // One control word per sequencer step.
  typedef struct packed {
    src_t     src;
    logic [1:0] lag;
    reg_idx_t coef;
    logic     clear;
    logic     sub;
    logic     chk_end;
  } ucode_t;

  // Control to the multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic clear;
    logic sub;
  } mac_ctl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      3'd0: w = '{SRC_X_CUR,  2'd0, REG_B_CUR,  1'b1, 1'b0, 1'b0};
      3'd1: w = '{SRC_X_HIST, 2'd1, REG_B_LAG1, 1'b0, 1'b0, 1'b0};
      3'd2: w = '{SRC_Y_HIST, 2'd1, REG_A_LAG1, 1'b0, 1'b1, 1'b1};
      3'd3: w = '{SRC_X_HIST, 2'd2, REG_B_LAG2, 1'b0, 1'b0, 1'b0};
      3'd4: w = '{SRC_Y_HIST, 2'd2, REG_A_LAG2, 1'b0, 1'b1, 1'b1};
      3'd5: w = '{SRC_X_HIST, 2'd3, REG_B_LAG3, 1'b0, 1'b0, 1'b0};
      3'd6: w = '{SRC_Y_HIST, 2'd3, REG_A_LAG3, 1'b0, 1'b1, 1'b1};
      default: w = '{SRC_X_CUR, 2'd3, REG_B_CUR, 1'b0, 1'b0, 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/iirdf1_if.sv
// Stream interfaces for the filter's input and result channels.
// Depends on iirdf1_pkg.
`default_nettype none

interface iirdf1_in_if
  import iirdf1_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirdf1_out_if
  import iirdf1_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    saturated;
  modport source (output valid, output sample_out, output saturated, input ready);
  modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

`default_nettype wire

FILE: rtl/iirdf1_mac.sv
// Shared multiply-accumulate unit: registered 16x24 product, then a wide
// accumulator that clears, adds or subtracts. Depends on iirdf1_pkg.
`default_nettype none

module iirdf1_mac
  import iirdf1_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire mac_ctl_t ctl,
  input  wire sample_t  opnd,
  input  wire coef_t    coef,
  output acc_t          acc
);

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 ctl_q;
  acc_t                     prod_ext;
  acc_t                     base;

  assign prod_ext = ACC_W'(prod);
  assign base     = ctl_q.clear ? '0 : acc;

  always_ff @(posedge clk) begin
    prod <= opnd * coef;
    if (ctl_q.en) begin
      acc <= ctl_q.sub ? base - prod_ext : base + prod_ext;
    end
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iir_direct_form_one_filter.sv
// Direct form I IIR filter, order ORDER (1..3), one shared MAC under microcode.
// One item at a time: an input beat is taken only in idle. The MAC steps then run
// (b current, then a b tap and an a tap per lag up to ORDER), the product and
// accumulate stages drain, and the result is handed out, once the output is free, on the way back to idle.
// Reset (rst, synchronous): coefficients to defaults (b current = 1.0),
// histories cleared, no result pending.
// Depends on iirdf1_pkg, iirdf1_if, iirdf1_mac.
`default_nettype none

module iir_direct_form_one_filter
  import iirdf1_pkg::*;
#(
  parameter int ORDER = DEF_ORDER
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_W-1:0] cfg_data,
  iirdf1_in_if.sink              in_stream,
  iirdf1_out_if.source           out_stream
);

  localparam int EffOrder = (ORDER < 1) ? 1 : ((ORDER > MAX_ORDER) ? MAX_ORDER : ORDER);
  localparam logic [1:0] LastLag = 2'(EffOrder);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

  state_t             state;
  logic [STEP_W-1:0]  step;
  coef_t              coefs [NUM_REGS];
  sample_t            x_cur;
  sample_t            xh [MAX_ORDER];
  sample_t            yh [MAX_ORDER];
  logic               out_valid;
  sample_t            out_sample;
  logic               out_sat;

  ucode_t             uw;
  mac_ctl_t           mctl;
  sample_t            opnd;
  coef_t              coef;
  acc_t               acc;
  acc_t               rnd;
  logic signed [23:0] y_wide;
  sample_t            y_sat;
  logic               y_clip;
  logic [1:0]         hidx;
  logic               out_free;

  assign uw   = ucode_rom(step);
  assign hidx = uw.lag - 2'd1;
  assign coef = coefs[uw.coef];
  assign mctl = '{en: (state == S_RUN), clear: uw.clear, sub: uw.sub};

  always_comb begin
    unique case (uw.src)
      SRC_X_CUR:  opnd = x_cur;
      SRC_X_HIST: opnd = xh[hidx];
      SRC_Y_HIST: opnd = yh[hidx];
      default:    opnd = x_cur;
    endcase
  end

  iirdf1_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mctl),
    .opnd (opnd),
    .coef (coef),
    .acc  (acc)
  );

  // round half up, floor shift, saturate
  assign rnd    = acc + ACC_W'(ROUND_BIAS);
  assign y_wide = 24'(rnd >>> FRAC_BITS);

  always_comb begin
    y_clip = 1'b1;
    if (y_wide > 24'sd32767) begin
      y_sat = 16'sh7fff;
    end else if (y_wide < -24'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat  = y_wide[15:0];
      y_clip = 1'b0;
    end
  end

  assign out_free = !out_valid || out_stream.ready;

  assign in_stream.ready       = (state == S_IDLE);
  assign out_stream.valid      = out_valid;
  assign out_stream.sample_out = out_sample;
  assign out_stream.saturated  = out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_ORDER; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
      coefs[0] <= COEF_B_CUR_RST;
      for (int i = 1; i < NUM_REGS; i++) begin
        coefs[i] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index < IDX_W'(NUM_REGS))) begin
        coefs[cfg_index] <= cfg_data;
      end
      if (out_valid && out_stream.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_stream.valid) begin
            x_cur <= in_stream.sample_in;
            step  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (uw.chk_end && (uw.lag == LastLag)) begin
            state <= S_DRAIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DRAIN: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_sample <= y_sat;
            out_sat    <= y_clip;
            xh[0]      <= x_cur;
            yh[0]      <= y_sat;
            for (int i = 1; i < MAX_ORDER; i++) begin
              xh[i] <= xh[i-1];
              yh[i] <= yh[i-1];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/iirdf1_checker.sv
// Port-level checks for the IIR filter, bound to the top level.
// Depends on iirdf1_pkg and iir_direct_form_one_filter.
`default_nettype none

module iirdf1_props
  import iirdf1_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    in_valid,
  input wire logic    in_ready,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire sample_t sample_out,
  input wire logic    saturated
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(saturated))
    else $error("result beat dropped or changed while stalled");

  // one item in flight: no input beat right after one was taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a clipped result sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> (sample_out == 16'sh7fff || sample_out == 16'sh8000))
    else $error("saturation flag without a rail value");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind iir_direct_form_one_filter iirdf1_props u_iirdf1_props (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_stream.valid),
  .in_ready   (in_stream.ready),
  .out_valid  (out_stream.valid),
  .out_ready  (out_stream.ready),
  .sample_out (out_stream.sample_out),
  .saturated  (out_stream.saturated)
);

`default_nettype wire

FILE: bench/iirdf1_checker.sv
// Scoreboard for the direct form I IIR filter: watches the register port and both
// stream channels, predicts every result and compares it with what comes out.
// Depends on iirdf1_pkg and iirdf1_if.

module iirdf1_checker
  import iirdf1_pkg::*;
#(
  parameter int ORDER = DEF_ORDER
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0] cfg_data,
  iirdf1_in_if                  in_mon,
  iirdf1_out_if                 out_mon,
  output int                    failures,
  output int                    pending,
  output int                    clipped
);

  localparam int LAGS = (ORDER < 1) ? 1 : ((ORDER > MAX_ORDER) ? MAX_ORDER : ORDER);
  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = -16'sh8000;

  typedef struct {
    sample_t value;
    logic    clip;
  } filt_result_t;

  coef_t        coef [NUM_REGS];
  sample_t      x_hist [1:MAX_ORDER];
  sample_t      y_hist [1:MAX_ORDER];
  filt_result_t expected_q [$];
  int           fail_count;
  int           clip_count;

  // Full-precision sum, round half up, clip; history keeps the clipped value.
  function automatic filt_result_t filter_sample(input sample_t x);
    filt_result_t r;
    longint       acc;
    longint       rounded;
    acc = longint'(x) * longint'(coef[REG_B_CUR]);
    for (int k = 1; k <= LAGS; k++) begin
      acc += longint'(x_hist[k]) * longint'(coef[int'(REG_B_LAG1) + k - 1]);
      acc -= longint'(y_hist[k]) * longint'(coef[int'(REG_A_LAG1) + k - 1]);
    end
    rounded = (acc + ROUND_BIAS) >>> FRAC_BITS;
    r.clip = 1'b1;
    if (rounded > longint'(SAMPLE_MAX)) r.value = SAMPLE_MAX;
    else if (rounded < longint'(SAMPLE_MIN)) r.value = SAMPLE_MIN;
    else begin
      r.value = sample_t'(rounded);
      r.clip = 1'b0;
    end
    for (int k = LAGS; k > 1; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[1] = x;
    y_hist[1] = r.value;
    return r;
  endfunction

  always @(posedge clk) begin
    filt_result_t want;
    if (rst) begin
      foreach (coef[i]) coef[i] = '0;
      coef[REG_B_CUR] = COEF_B_CUR_RST;
      foreach (x_hist[i]) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      expected_q.delete();
      fail_count = 0;
      clip_count = 0;
    end else begin
      if (cfg_we && cfg_index < NUM_REGS) coef[cfg_index] = coef_t'(cfg_data);
      if (in_mon.valid && in_mon.ready) begin
        want = filter_sample(in_mon.sample_in);
        if (want.clip) clip_count++;
        expected_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, sample_out %0d saturated %0b", $time,
                   out_mon.sample_out, out_mon.saturated);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.sample_out !== want.value) begin
            $display("%0t: sample_out expected %0d, got %0d", $time, want.value,
                     out_mon.sample_out);
            fail_count++;
          end
          if (out_mon.saturated !== want.clip) begin
            $display("%0t: saturated expected %0b, got %0b", $time, want.clip,
                     out_mon.saturated);
            fail_count++;
          end
        end
      end
    end
    failures <= fail_count;
    pending  <= expected_q.size();
    clipped  <= clip_count;
  end

endmodule

FILE: bench/testbench.sv
// Top of the IIR filter bench: clock, reset, coefficient writes, sample and
// back-pressure stimulus, watchdog and verdict.
// Depends on iirdf1_pkg, iirdf1_if, iir_direct_form_one_filter and iirdf1_checker.

module testbench;
  import iirdf1_pkg::*;

  localparam int ORDER       = DEF_ORDER;
  localparam int LATENCY     = 2 * ORDER + 4;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(NUM_REGS);
  localparam coef_t COEF_MAX   = 24'sh7fffff;
  localparam coef_t COEF_MIN   = -24'sh800000;
  localparam coef_t COEF_UNITY = 24'sh100000;
  localparam coef_t COEF_HALF  = 24'sh080000;

  typedef enum int {MODE_FULL, MODE_GENTLE, MODE_EXTREME} coef_mode_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0] cfg_data;
  logic              calm;
  logic              hold_req;
  bit                hold_done;
  int                failures;
  int                pending;
  int                clipped;
  int                samples_sent;
  int                sets_applied;
  int                stall_cycles;

  iirdf1_in_if  in_bus ();
  iirdf1_out_if out_bus ();

  iir_direct_form_one_filter #(.ORDER(ORDER)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stream  (in_bus),
    .out_stream (out_bus)
  );

  iirdf1_checker #(.ORDER(ORDER)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .failures  (failures),
    .pending   (pending),
    .clipped   (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no beat for %0d cycles, pending %0d", stall_cycles, pending);
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: bursts of stalls, one long hold-off on request, none when calm.
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_sample(input sample_t x);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= x;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    samples_sent++;
  endtask

  // Drain, let the pipeline settle, then write the whole bank and, if asked, the unused index.
  task automatic write_coefs(input coef_t bank [NUM_REGS], input bit poke_unused);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= bank[i];
      @(posedge clk);
    end
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= '1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    sets_applied++;
  endtask

  function automatic coef_t pick_coef(input coef_mode_t mode);
    case (mode)
      MODE_GENTLE: return coef_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      MODE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return COEF_UNITY;
          3: return -COEF_UNITY;
          default: return '0;
        endcase
      end
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return sample_t'($urandom);
    if (r < 17) return sample_t'(int'($urandom_range(0, 511)) - 256);
    case ($urandom_range(0, 3))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return -16'sh0001;
      default: return '0;
    endcase
  endfunction

  initial begin
    coef_t bank [NUM_REGS];
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_B_CUR;
    cfg_data         <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.sample_in <= '0;
    calm             <= 1'b0;
    hold_req         <= 1'b0;
    samples_sent = 0;
    sets_applied = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: straight through
    send_sample(16'sh0000);
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh0001);
    send_sample(-16'sh0001);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);

    // extreme gains, clipping both ways
    bank[REG_B_CUR]  = COEF_MAX;
    bank[REG_B_LAG1] = COEF_MIN;
    bank[REG_B_LAG2] = COEF_UNITY;
    bank[REG_B_LAG3] = -COEF_UNITY;
    bank[REG_A_LAG1] = COEF_MAX;
    bank[REG_A_LAG2] = COEF_MIN;
    bank[REG_A_LAG3] = COEF_HALF;
    write_coefs(bank, 1'b0);
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh0004);
    send_sample(16'sh0000);
    send_sample(16'sh0000);

    // half gain: exact halves round upwards; write to the unused index is dropped
    foreach (bank[i]) bank[i] = '0;
    bank[REG_B_CUR] = COEF_HALF;
    write_coefs(bank, 1'b1);
    send_sample(16'sh0001);
    send_sample(-16'sh0001);
    send_sample(16'sh0003);
    send_sample(-16'sh0003);
    send_sample(16'sh0000);

    for (int p = 0; p < PHASES; p++) begin
      foreach (bank[i]) bank[i] = pick_coef(coef_mode_t'(p % 3));
      write_coefs(bank, p[0]);
      if (p == 1) hold_req <= 1'b1;
      if (p == PHASES - 1) calm <= 1'b1;
      repeat (PHASE_ITEMS) send_sample(pick_sample());
    end

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("%0d samples through %0d coefficient banks, %0d results clipped,",
             samples_sent, sets_applied, clipped);
    $display("including a long result hold-off and a calm closing phase");
    if (failures == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: iir_direct_form_one_filter.f
rtl/iirdf1_pkg.sv
rtl/iirdf1_if.sv
rtl/iirdf1_mac.sv
rtl/iir_direct_form_one_filter.sv
rtl/iirdf1_checker.sv
bench/iirdf1_checker.sv
bench/testbench.sv
